[sv/bmc_pkg.sv]
package bmc_pkg;

   localparam int MatrixSize = 64;
   localparam int WordWidth = 64;
   localparam int IdxWidth = 6;
   localparam int CsrIdxWidth = 3;
   localparam int RotateAmountDefault = 1;
   localparam int QueueDepthDefault = 4;

   localparam logic [WordWidth-1:0] WaveAddP = 64'h19062C1485FB27AE;
   localparam logic [WordWidth-1:0] WaveSubN = 64'hE7FAE3EB8B04C961;
   localparam int WaveStep = 11;
   localparam int TableRot = 3;

   // The wave rotor terms collapse to a constant minus a rotated word.
   localparam logic [WordWidth-1:0] WaveLeftK = ~WaveAddP - WaveSubN;
   localparam logic [WordWidth-1:0] WaveRightK = WaveSubN + WaveAddP - 64'd1;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_ROW_KEY_LOW  = 3'd0,
      CSR_ROW_KEY_HIGH = 3'd1,
      CSR_COL_KEY_LOW  = 3'd2,
      CSR_COL_KEY_HIGH = 3'd3,
      CSR_DECRYPT_MODE = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_DATA   = 2'd0,
      CMD_FILL   = 2'd1,
      CMD_STEP   = 2'd2,
      CMD_RELOAD = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]           cmd;
      logic [WordWidth-1:0] data_word;
   } req_type;

   typedef struct packed {
      logic [WordWidth-1:0] word_out;
      logic                 last_word;
   } rsp_type;

   typedef struct packed {
      op_type               op;
      logic                 block_end;
      logic [WordWidth-1:0] word;
   } item_type;

   typedef struct packed {
      logic [WordWidth-1:0] row_key_low;
      logic [WordWidth-1:0] row_key_high;
      logic [WordWidth-1:0] col_key_low;
      logic [WordWidth-1:0] col_key_high;
      logic                 decrypt_mode;
   } cfg_type;

   function automatic logic [WordWidth-1:0] rol_step(input logic [WordWidth-1:0] m);
      return (m << WaveStep) | (m >> (WordWidth - WaveStep));
   endfunction

   function automatic logic [WordWidth-1:0] ror_step(input logic [WordWidth-1:0] m);
      return (m >> WaveStep) | (m << (WordWidth - WaveStep));
   endfunction

   function automatic logic [WordWidth-1:0] rol_table(input logic [WordWidth-1:0] m);
      return (m << TableRot) | (m >> (WordWidth - TableRot));
   endfunction

endpackage

[sv/bmc_front.sv]
module bmc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  bmc_pkg::req_type   req_data,
   input  logic               q_full,
   output logic               q_push,
   output bmc_pkg::item_type  q_item
);

   logic [bmc_pkg::IdxWidth-1:0] rows_ff;
   logic [bmc_pkg::IdxWidth-1:0] rows_in;
   bmc_pkg::op_type              op;

   assign req_ready = !q_full;
   assign q_push = req_valid && !q_full;

   always_comb begin
      case (req_data.cmd)
         bmc_pkg::CMD_DATA:   op = bmc_pkg::CMD_DATA;
         bmc_pkg::CMD_FILL:   op = bmc_pkg::CMD_FILL;
         bmc_pkg::CMD_STEP:   op = bmc_pkg::CMD_STEP;
         bmc_pkg::CMD_RELOAD: op = bmc_pkg::CMD_RELOAD;
         default:             op = bmc_pkg::CMD_DATA;
      endcase
   end

   // The row that fills the matrix is tagged so the back end starts the passes.
   always_comb begin
      q_item.op = op;
      q_item.word = req_data.data_word;
      q_item.block_end = (op == bmc_pkg::CMD_DATA) && (rows_ff == {bmc_pkg::IdxWidth{1'b1}});
      rows_in = rows_ff;
      if (q_push && op == bmc_pkg::CMD_DATA) begin
         rows_in = rows_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= '0;
      end else begin
         rows_ff <= rows_in;
      end
   end

endmodule

[sv/bmc_queue.sv]
module bmc_queue #(
   parameter int DEPTH = bmc_pkg::QueueDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bmc_pkg::item_type  push_item,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output bmc_pkg::item_type  head
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

   bmc_pkg::item_type     slot_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;

   assign full = (cnt_ff == FullCnt);
   assign not_empty = (cnt_ff != '0);
   assign head = slot_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == LastPtr) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == LastPtr) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> (!full || pop))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> not_empty)
      else $error("queue read while empty");

endmodule

[sv/bmc_back.sv]
module bmc_back #(
   parameter int ROTATE_AMOUNT = bmc_pkg::RotateAmountDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  bmc_pkg::cfg_type   cfg,
   input  logic               item_valid,
   input  bmc_pkg::item_type  item,
   output logic               item_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bmc_pkg::rsp_type   rsp_data
);

   localparam int W = bmc_pkg::WordWidth;
   localparam int N = bmc_pkg::MatrixSize;
   localparam int IW = bmc_pkg::IdxWidth;
   localparam logic [IW-1:0] TapNext = IW'(ROTATE_AMOUNT);
   localparam logic [IW-1:0] TapPrev = IW'(N - ROTATE_AMOUNT);
   localparam logic [IW-1:0] LastIdx = IW'(N - 1);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_FILL   = 6'b000010,
      ST_P1_PRE = 6'b000100,
      ST_P1     = 6'b001000,
      ST_P2_PRE = 6'b010000,
      ST_P2     = 6'b100000
   } state_type;

   typedef enum logic [2:0] {
      FP_A  = 3'b001,
      FP_B  = 3'b010,
      FP_WR = 3'b100
   } fill_phase_type;

   function automatic logic [W-1:0] row_op(input logic [W-1:0] x, input logic lo,
                                           input logic hi);
      logic [W-1:0] y;
      case ({hi, lo})
         2'b01:   y = (x << ROTATE_AMOUNT) | (x >> (W - ROTATE_AMOUNT));
         2'b10:   y = (x >> ROTATE_AMOUNT) | (x << (W - ROTATE_AMOUNT));
         2'b11:   y = ~x;
         default: y = x;
      endcase
      return y;
   endfunction

   state_type      state_ff, state_in;
   fill_phase_type phase_ff, phase_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic           mode_ff, mode_in;
   logic [W-1:0]   h0_ff, h0_in, h1_ff, h1_in, v0_ff, v0_in, v1_ff, v1_in;
   logic [W-1:0]   a_ff, a_in, b_ff, b_in;
   logic [W-1:0]   line_ff [N];
   logic [W-1:0]   line_in [N];
   logic           line_we;

   logic [W-1:0]   tab_mem [N];
   logic [N-1:0]   tab_vld_ff;
   logic [W-1:0]   tab_rd_ff;
   logic           tab_rd_vld_ff;
   logic           tab_re, tab_we;
   logic [IW-1:0]  tab_raddr;
   logic [W-1:0]   tab_wdata, tab_val;

   logic           rsp_valid_ff, rsp_valid_in;
   bmc_pkg::rsp_type rsp_ff, rsp_in;

   logic           advance;
   logic           row_lo, row_hi;
   logic [W-1:0]   kl, kr, m_keep, m_left, m_right, m_inv, col_word;

   assign tab_val = tab_rd_vld_ff ? tab_rd_ff : '0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign item_pop = (state_ff == ST_IDLE) && item_valid;
   assign advance = (state_ff == ST_P2) && (!rsp_valid_ff || rsp_ready);

   // Decryption swaps the two key words, which trades left and right rotation.
   always_comb begin
      row_lo = mode_ff ? h1_ff[idx_ff] : h0_ff[idx_ff];
      row_hi = mode_ff ? h0_ff[idx_ff] : h1_ff[idx_ff];
      kl = mode_ff ? v1_ff : v0_ff;
      kr = mode_ff ? v0_ff : v1_ff;
      m_keep = ~(v0_ff | v1_ff);
      m_inv = v0_ff & v1_ff;
      m_left = kl & ~kr;
      m_right = kr & ~kl;
      // A column rotation moves bit c between rows of the line ROTATE_AMOUNT apart.
      col_word = (line_ff[0] & m_keep) | (~line_ff[0] & m_inv)
               | (line_ff[TapPrev] & m_left) | (line_ff[TapNext] & m_right);
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      idx_in = idx_ff;
      mode_in = mode_ff;
      h0_in = h0_ff;
      h1_in = h1_ff;
      v0_in = v0_ff;
      v1_in = v1_ff;
      a_in = a_ff;
      b_in = b_ff;
      line_we = 1'b0;
      for (int j = 0; j < N - 1; j++) begin
         line_in[j] = line_ff[j + 1];
      end
      line_in[N - 1] = line_ff[0];
      tab_re = 1'b0;
      tab_raddr = idx_ff + 1'b1;
      tab_we = 1'b0;
      tab_wdata = tab_val + bmc_pkg::rol_table(a_ff ^ b_ff);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               case (item.op)
                  bmc_pkg::CMD_DATA: begin
                     line_we = 1'b1;
                     line_in[N - 1] = item.word;
                     if (item.block_end) begin
                        mode_in = cfg.decrypt_mode;
                        idx_in = '0;
                        state_in = ST_P1_PRE;
                     end
                  end
                  bmc_pkg::CMD_FILL: begin
                     a_in = v1_ff + h0_ff;
                     b_in = v0_ff + h1_ff;
                     idx_in = '0;
                     phase_in = FP_A;
                     state_in = ST_FILL;
                  end
                  bmc_pkg::CMD_STEP: begin
                     h1_in = bmc_pkg::WaveLeftK - bmc_pkg::rol_step(h1_ff);
                     h0_in = bmc_pkg::WaveRightK - bmc_pkg::ror_step(h0_ff);
                     v1_in = bmc_pkg::WaveLeftK - bmc_pkg::rol_step(v1_ff);
                     v0_in = bmc_pkg::WaveRightK - bmc_pkg::ror_step(v0_ff);
                  end
                  bmc_pkg::CMD_RELOAD: begin
                     h0_in = cfg.row_key_low;
                     h1_in = cfg.row_key_high;
                     v0_in = cfg.col_key_low;
                     v1_in = cfg.col_key_high;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_FILL: begin
            case (phase_ff)
               FP_A: begin
                  tab_re = 1'b1;
                  tab_raddr = idx_ff;
                  a_in = a_ff + bmc_pkg::WaveLeftK - bmc_pkg::rol_step(b_ff);
                  phase_in = FP_B;
               end
               FP_B: begin
                  b_in = b_ff + bmc_pkg::WaveRightK - bmc_pkg::rol_step(a_ff);
                  phase_in = FP_WR;
               end
               FP_WR: begin
                  tab_we = 1'b1;
                  idx_in = idx_ff + 1'b1;
                  phase_in = FP_A;
                  if (idx_ff == LastIdx) begin
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  phase_in = FP_A;
               end
            endcase
         end
         ST_P1_PRE: begin
            tab_re = 1'b1;
            tab_raddr = '0;
            state_in = ST_P1;
         end
         ST_P1: begin
            tab_re = 1'b1;
            line_we = 1'b1;
            line_in[N - 1] = mode_ff ? line_ff[0] - tab_val : row_op(line_ff[0], row_lo, row_hi);
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LastIdx) begin
               state_in = ST_P2_PRE;
            end
         end
         ST_P2_PRE: begin
            tab_re = 1'b1;
            tab_raddr = '0;
            state_in = ST_P2;
         end
         ST_P2: begin
            if (advance) begin
               tab_re = 1'b1;
               line_we = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in.word_out = mode_ff ? row_op(col_word, row_lo, row_hi) : col_word + tab_val;
               rsp_in.last_word = (idx_ff == LastIdx);
               idx_in = idx_ff + 1'b1;
               if (idx_ff == LastIdx) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (line_we) begin
         for (int j = 0; j < N; j++) begin
            line_ff[j] <= line_in[j];
         end
      end
      if (tab_re) begin
         tab_rd_ff <= tab_mem[tab_raddr];
         tab_rd_vld_ff <= tab_vld_ff[tab_raddr];
      end
      if (tab_we) begin
         tab_mem[idx_ff] <= tab_wdata;
      end
      phase_ff <= phase_in;
      idx_ff <= idx_in;
      mode_ff <= mode_in;
      a_ff <= a_in;
      b_ff <= b_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tab_vld_ff <= '0;
         h0_ff <= '0;
         h1_ff <= '0;
         v0_ff <= '0;
         v1_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (tab_we) begin
            tab_vld_ff[idx_ff] <= 1'b1;
         end
         h0_ff <= h0_in;
         h1_ff <= h1_in;
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_stall_holds_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P2 && rsp_valid_ff && !rsp_ready) |=> $stable(idx_ff))
      else $error("row index moved while the output beat was stalled");
   a_pass2_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P2_PRE) |-> (idx_ff == '0))
      else $error("column pass does not start at row zero");
   a_pass1_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P1 && idx_ff == LastIdx) |=> (state_ff == ST_P2_PRE))
      else $error("row pass did not hand over to the column pass");
   a_last_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (advance && idx_ff != LastIdx) |=> !rsp_ff.last_word)
      else $error("last flag set before the final row");

endmodule

[sv/bit_matrix_block_cipher_top.sv]
// Bit-matrix block cipher. Each request beat carries a command: data rows are
// collected into a 64 x 64 bit matrix, and the row that completes the matrix
// starts processing, after which the 64 result rows leave as response beats in
// row order with last_word set on the final one. The other commands refill the
// additive table from the working key (accumulating into it), step the working
// key through the wave rotor, or reload it from the key registers; they take
// effect at once, also in the middle of a block, and produce no response.
// A request queue, four beats deep by default, sits in front of the engine, so
// requests keep flowing while it works until the queue fills. The engine
// handles a data row, a key step or a reload in its idle state. A completed
// block then runs two sweeps over the shift line that holds the matrix, a row
// pass and a column pass, each preceded by a state that fetches the first
// table word, and the second sweep waits whenever the response beat is
// stalled. A table refill seeds the two rotor words, then steps through three
// phases per table word, set by the dependent wave rotor adds. Configuration
// is written through a plain write port and should only change while the
// block is idle; decrypt_mode is sampled when a block completes.
module bit_matrix_block_cipher_top #(
   parameter int ROTATE_AMOUNT = bmc_pkg::RotateAmountDefault,
   parameter int QUEUE_DEPTH = bmc_pkg::QueueDepthDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bmc_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bmc_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [bmc_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [bmc_pkg::WordWidth-1:0]       csr_wdata
);

   // Key and mode registers; writes to indexes beyond the list are dropped.
   bmc_pkg::cfg_type  cfg_ff, cfg_in;

   // Front end to queue.
   logic              q_push, q_full;
   bmc_pkg::item_type q_item;

   // Queue to engine.
   logic              q_pop, q_not_empty;
   bmc_pkg::item_type q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            bmc_pkg::CSR_ROW_KEY_LOW:  cfg_in.row_key_low = csr_wdata;
            bmc_pkg::CSR_ROW_KEY_HIGH: cfg_in.row_key_high = csr_wdata;
            bmc_pkg::CSR_COL_KEY_LOW:  cfg_in.col_key_low = csr_wdata;
            bmc_pkg::CSR_COL_KEY_HIGH: cfg_in.col_key_high = csr_wdata;
            bmc_pkg::CSR_DECRYPT_MODE: cfg_in.decrypt_mode = csr_wdata[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end classifies each beat and tags the row that fills the matrix.
   bmc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_item)
   );

   bmc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // The engine holds the keys, the table memory and the matrix shift line.
   bmc_back #(
      .ROTATE_AMOUNT (ROTATE_AMOUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (q_not_empty),
      .item       (q_head),
      .item_pop   (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
